@@ rtl/mrb_pkg.sv @@
// ----------------------------------------------------------------------------
// mrb_pkg
// shared types, constants and functions of the modbus read-bits slave
// ----------------------------------------------------------------------------
package mrb_pkg;

    localparam int unsigned FRAME_LEN  = 8;
    localparam int unsigned REPLY_LEN  = 6;
    localparam int unsigned NUM_POINTS = 8;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  SILENCE_RESET = 8'd5;
    localparam logic [7:0]  COUNT_MAX     = 8'd255;
    localparam logic [7:0]  BYTE_COUNT    = 8'd1;

    // item kinds carried on tuser
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // function codes served
    localparam logic [7:0] FN_READ_COILS  = 8'h01;
    localparam logic [7:0] FN_READ_INPUTS = 8'h02;

    // reply byte positions
    localparam logic [2:0] RPL_ADDR   = 3'd0;
    localparam logic [2:0] RPL_FN     = 3'd1;
    localparam logic [2:0] RPL_COUNT  = 3'd2;
    localparam logic [2:0] RPL_DATA   = 3'd3;
    localparam logic [2:0] RPL_CRC_LO = 3'd4;
    localparam logic [2:0] RPL_CRC_HI = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_SEND
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic start;      // closing tick with a good request
        logic crc_step;   // fold one reply byte into the crc
        logic send_step;  // output transfer this cycle
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic reply_go;   // current input would close a good request
        logic walk_done;  // last header byte folded in
        logic tx_done;    // final reply byte on the bus
    } t_sts;

    // one byte of crc-16/modbus, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // up to eight point bits starting at point start-1
    function automatic logic [7:0] gather(input logic [15:0] start,
                                          input logic [15:0] qty,
                                          input logic [7:0]  states);
        logic [7:0]  d;
        logic [16:0] p;
        logic [16:0] pm;
        d = 8'h00;
        for (int i = 0; i < 8; i++) begin
            p  = {1'b0, start} + 17'(i);
            pm = p - 17'd1;
            if ((17'({1'b0, qty}) > 17'(i)) && (p != 17'd0)
                    && (pm < 17'(NUM_POINTS))) begin
                d[i] = states[pm[2:0]];
            end
        end
        return d;
    endfunction

endpackage

@@ rtl/mrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrb_ctrl
// handshake control: idle/receive, reply crc walk, reply transmit
// ----------------------------------------------------------------------------
module mrb_ctrl import mrb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_sts.reply_go) begin
                    n_state = ST_CRC;
                end
            end
            ST_CRC: begin
                if (i_sts.walk_done) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (i_out_ready && i_sts.tx_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        o_out_valid     = (r_state == ST_SEND);
        o_cmd.accept    = o_in_ready && i_in_valid;
        o_cmd.start     = o_cmd.accept && i_sts.reply_go;
        o_cmd.crc_step  = (r_state == ST_CRC);
        o_cmd.send_step = o_out_valid && i_out_ready;
    end

endmodule

@@ rtl/mrb_dpath.sv @@
// ----------------------------------------------------------------------------
// mrb_dpath
// frame store, counters, request check and reply builder
// ----------------------------------------------------------------------------
module mrb_dpath import mrb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_cmd_kind,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_coil_states,
    input  logic [7:0] i_input_states,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic [7:0] o_tx_byte,
    output logic       o_last
);

    logic [7:0]  r_store [FRAME_LEN];
    logic [7:0]  r_byte_count;
    logic [7:0]  r_silence_count;
    logic [7:0]  r_silence_ticks;
    logic [15:0] r_rx_crc;
    logic [15:0] r_tx_crc;
    logic [7:0]  r_data;
    logic [2:0]  r_idx;

    logic [7:0]  n_silence;
    logic        is_tick;
    logic        counting;
    logic        closing;
    logic        frame_ok;
    logic [15:0] crc_seed;
    logic [7:0]  reply_byte;

    assign is_tick   = (i_cmd_kind == CMD_TICK);
    assign counting  = is_tick && (r_byte_count >= 8'(FRAME_LEN));
    assign n_silence = (r_silence_count == COUNT_MAX) ? COUNT_MAX
                                                      : r_silence_count + 8'd1;
    assign closing   = counting && (n_silence >= r_silence_ticks);
    assign frame_ok  = (r_byte_count == 8'(FRAME_LEN))
                    && ({r_store[7], r_store[6]} == r_rx_crc)
                    && ((r_store[1] == FN_READ_COILS) || (r_store[1] == FN_READ_INPUTS));
    assign crc_seed  = (r_byte_count == 8'd0) ? CRC_INIT : r_rx_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence_ticks <= SILENCE_RESET;
        end else if (i_cfg_we) begin
            r_silence_ticks <= i_cfg_data;
        end
    end

    // receive side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= 8'd0;
            r_silence_count <= 8'd0;
        end else if (i_cmd.accept) begin
            if (!is_tick) begin
                if (r_byte_count != COUNT_MAX) begin
                    r_byte_count <= r_byte_count + 8'd1;
                end
                r_silence_count <= 8'd0;
            end else if (closing) begin
                r_byte_count    <= 8'd0;
                r_silence_count <= 8'd0;
            end else if (counting) begin
                r_silence_count <= n_silence;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !is_tick) begin
            if (r_byte_count < 8'(FRAME_LEN)) begin
                r_store[r_byte_count[2:0]] <= i_rx_byte;
            end
            // crc over the six request bytes ahead of the check field
            if (r_byte_count < 8'(FRAME_LEN - 2)) begin
                r_rx_crc <= crc_byte(crc_seed, i_rx_byte);
            end
        end
    end

    // reply side
    always_comb begin
        unique case (r_idx)
            RPL_ADDR:   reply_byte = r_store[0];
            RPL_FN:     reply_byte = r_store[1];
            RPL_COUNT:  reply_byte = BYTE_COUNT;
            RPL_DATA:   reply_byte = r_data;
            RPL_CRC_LO: reply_byte = r_tx_crc[7:0];
            RPL_CRC_HI: reply_byte = r_tx_crc[15:8];
            default:    reply_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= RPL_ADDR;
        end else if (i_cmd.start) begin
            r_idx <= RPL_ADDR;
        end else if (i_cmd.crc_step) begin
            r_idx <= (r_idx == RPL_DATA) ? RPL_ADDR : r_idx + 3'd1;
        end else if (i_cmd.send_step) begin
            r_idx <= (r_idx == RPL_CRC_HI) ? RPL_ADDR : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_data   <= gather({r_store[2], r_store[3]}, {r_store[4], r_store[5]},
                               (r_store[1] == FN_READ_COILS) ? i_coil_states
                                                             : i_input_states);
            r_tx_crc <= CRC_INIT;
        end else if (i_cmd.crc_step) begin
            r_tx_crc <= crc_byte(r_tx_crc, reply_byte);
        end
    end

    assign o_sts.reply_go  = closing && frame_ok;
    assign o_sts.walk_done = (r_idx == RPL_DATA);
    assign o_sts.tx_done   = (r_idx == RPL_CRC_HI);
    assign o_tx_byte       = reply_byte;
    assign o_last          = (r_idx == RPL_CRC_HI);

endmodule

@@ rtl/modbus_rtu_read_bits_slave.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_read_bits_slave
// modbus rtu slave answering read coils and read discrete inputs
// ----------------------------------------------------------------------------
// usage
//   s_axis: one transfer per item; tuser 0 = received byte, 1 = timer tick.
//     tdata carries the byte and the current coil and input states.
//   m_axis: reply bytes, one per transfer, tlast on the sixth byte.
//   cfg: one write sets the silence tick count (reset value 5); write it
//     only while no reply is pending.
// timing
//   a received byte or a tick is taken in the cycle of its transfer.
//   a tick that closes a good request starts a crc walk over the four-byte
//   reply header (one byte per cycle through the crc unit), after which the
//   six reply bytes go out at one per cycle while the sink is ready.
//   s_axis tready is low from the closing tick until the final byte's
//   transfer; a stalled sink simply holds the current reply byte.
// reset
//   synchronous active low; clears byte and silence counts, the controller
//   and restores the silence tick count. the frame store is not cleared.
// ----------------------------------------------------------------------------
module modbus_rtu_read_bits_slave import mrb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,       // silence_ticks
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [7:0] rx_byte, [15:8] coil_states,
                                          // [23:16] input_states
    input  logic        i_s_axis_tuser,   // [0] cmd
    // reply stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] tx_byte
    output logic        o_m_axis_tlast    // last
);

    t_cmd cmd;
    t_sts sts;

    // register is always writable; the user keeps writes to idle periods
    assign o_cfg_ready = 1'b1;

    mrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mrb_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_cmd_kind     (i_s_axis_tuser),
        .i_rx_byte      (i_s_axis_tdata[7:0]),
        .i_coil_states  (i_s_axis_tdata[15:8]),
        .i_input_states (i_s_axis_tdata[23:16]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_tx_byte      (o_m_axis_tdata),
        .o_last         (o_m_axis_tlast)
    );

`ifndef SYNTHESIS
    // receive and transmit never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while a reply byte is offered");

    // the crc walk always separates an accepted item from the first reply byte
    a_walk_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_m_axis_tvalid)
        else $error("reply byte offered right after an input transfer");

    // after the final byte the block is ready for input again
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> o_s_axis_tready)
        else $error("not ready after final reply byte");

    // a reply starts with a byte that is not flagged last
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !o_m_axis_tlast)
        else $error("reply started on a last byte");
`endif

endmodule

@@ verif/mrb_reply_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrb_reply_checker
// watches the request, reply and configuration channels of the read-bits
// slave, predicts every reply byte and compares it with what leaves the block
// ----------------------------------------------------------------------------
package mrb_tb_pkg;

    import mrb_pkg::*;

    // one byte of crc-16/modbus, fed bit by bit from the lsb
    function automatic logic [15:0] crc_fold(input logic [15:0] crc,
                                             input logic [7:0]  octet);
        logic [15:0] r;
        r = crc;
        for (int b = 0; b < 8; b++) begin
            if (r[0] ^ octet[b]) begin
                r = {1'b0, r[15:1]} ^ CRC_POLY;
            end else begin
                r = {1'b0, r[15:1]};
            end
        end
        return r;
    endfunction

endpackage

module mrb_reply_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic        i_m_tlast,
    output int          o_errors,
    output int          o_backlog
);

    import mrb_pkg::*;
    import mrb_tb_pkg::*;

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
    } t_reply_byte;

    t_reply_byte reply_q[$];
    logic [7:0]  frame_mem [FRAME_LEN];
    logic [7:0]  rx_count;
    logic [7:0]  quiet_count;
    logic [7:0]  silence_ticks;
    int          errors = 0;

    // data byte of a read request, points outside the map read 0
    function automatic logic [7:0] point_bits(input logic [7:0] states);
        int unsigned first;
        int unsigned qty;
        int unsigned p;
        logic [7:0]  d;
        first = {frame_mem[2], frame_mem[3]};
        qty   = {frame_mem[4], frame_mem[5]};
        d     = '0;
        if (qty > 8) begin
            qty = 8;
        end
        for (int i = 0; i < 8; i++) begin
            p = first + i;
            if (i < qty && p >= 1 && p - 1 < NUM_POINTS) begin
                d[i] = states[p - 1];
            end
        end
        return d;
    endfunction

    task automatic close_request(input logic [7:0] coils, input logic [7:0] inputs);
        logic [15:0] crc;
        logic [7:0]  reply [REPLY_LEN];
        t_reply_byte rb;
        if (rx_count != FRAME_LEN) begin
            return;
        end
        crc = CRC_INIT;
        for (int k = 0; k < 6; k++) begin
            crc = crc_fold(crc, frame_mem[k]);
        end
        if (frame_mem[6] != crc[7:0] || frame_mem[7] != crc[15:8]) begin
            return;
        end
        if (frame_mem[1] != FN_READ_COILS && frame_mem[1] != FN_READ_INPUTS) begin
            return;
        end
        reply[RPL_ADDR]  = frame_mem[0];
        reply[RPL_FN]    = frame_mem[1];
        reply[RPL_COUNT] = BYTE_COUNT;
        reply[RPL_DATA]  = point_bits(frame_mem[1] == FN_READ_COILS ? coils : inputs);
        crc = CRC_INIT;
        for (int k = 0; k < 4; k++) begin
            crc = crc_fold(crc, reply[k]);
        end
        reply[RPL_CRC_LO] = crc[7:0];
        reply[RPL_CRC_HI] = crc[15:8];
        for (int k = 0; k < REPLY_LEN; k++) begin
            rb.octet = reply[k];
            rb.last  = (k == REPLY_LEN - 1);
            reply_q.push_back(rb);
        end
    endtask

    task automatic take_item(input logic cmd, input logic [23:0] word);
        if (cmd == CMD_BYTE) begin
            if (rx_count < FRAME_LEN) begin
                frame_mem[rx_count[2:0]] = word[7:0];
            end
            if (rx_count != COUNT_MAX) begin
                rx_count++;
            end
            quiet_count = '0;
        end else if (rx_count >= FRAME_LEN) begin
            if (quiet_count != COUNT_MAX) begin
                quiet_count++;
            end
            if (quiet_count >= silence_ticks) begin
                close_request(word[15:8], word[23:16]);
                quiet_count = '0;
                rx_count    = '0;
            end
        end
    endtask

    // sampled mid-cycle: these are the values the next rising edge takes
    always @(negedge i_clk) begin : watch
        t_reply_byte want;
        if (!i_rst_n) begin
            rx_count      = '0;
            quiet_count   = '0;
            silence_ticks = SILENCE_RESET;
            reply_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                silence_ticks = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                take_item(i_s_tuser, i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (reply_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("reply byte %02h last %0b with no reply pending",
                                 i_m_tdata, i_m_tlast);
                    end
                end else begin
                    want = reply_q.pop_front();
                    if (want.octet !== i_m_tdata || want.last !== i_m_tlast) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("reply byte mismatch: expected %02h last %0b, got %02h last %0b",
                                     want.octet, want.last, i_m_tdata, i_m_tlast);
                        end
                    end
                end
            end
        end
        o_errors  = errors;
        o_backlog = reply_q.size();
    end

endmodule

@@ verif/tb_modbus_rtu_read_bits_slave.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_read_bits_slave
// drives request bytes and timer ticks into the read-bits slave, with a
// checker beside it; good, corrupted, over-long, short and interrupted frames
// run under several silence settings and idle and stall patterns
// ----------------------------------------------------------------------------
module tb_modbus_rtu_read_bits_slave;

    import mrb_pkg::*;
    import mrb_tb_pkg::*;

    localparam int STALL_LIMIT  = 3000;  // cycles without any transfer
    localparam int DRAIN_CYCLES = 20;    // lets a reply the checker did not predict show up

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data   = '0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata    = '0;    // [7:0] rx_byte, [15:8] coils, [23:16] inputs
    logic        s_tuser    = 1'b0;  // [0] cmd
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] tx_byte
    logic        m_tlast;

    int          idle_pct    = 0;    // chance per cycle that the sender holds off
    int          stall_pct   = 0;    // chance per cycle that the sink is not ready
    logic [7:0]  cur_silence = SILENCE_RESET;
    int          items_sent  = 0;
    int          errors;
    int          backlog;

    always #5 i_clk = ~i_clk;

    modbus_rtu_read_bits_slave dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    mrb_reply_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .o_errors    (errors),
        .o_backlog   (backlog)
    );

    // sink side back-pressure
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ends the run if no transfer happens on any channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(negedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // one input transfer; valid is left high so back-to-back items need no gap
    task automatic put_item(input logic cmd, input logic [7:0] rx,
                            input logic [7:0] coils, input logic [7:0] inputs);
        int   gap;
        logic took;
        gap = 0;
        while ($urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {inputs, coils, rx};
        do begin
            @(negedge i_clk);
            took = s_tready;
            @(posedge i_clk);
        end while (!took);
        items_sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        put_item(CMD_BYTE, b, 8'($urandom), 8'($urandom));
    endtask

    task automatic put_tick();
        put_item(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // eight-byte read request, optionally with one bit flipped after the crc
    task automatic put_request(input logic [7:0] addr, input logic [7:0] fn,
                               input logic [15:0] first, input logic [15:0] qty,
                               input logic corrupt);
        logic [7:0]  pdu [FRAME_LEN];
        logic [15:0] crc;
        int          pos;
        int          bitn;
        pdu = '{addr, fn, first[15:8], first[7:0], qty[15:8], qty[7:0], 8'h00, 8'h00};
        crc = CRC_INIT;
        for (int k = 0; k < 6; k++) begin
            crc = crc_fold(crc, pdu[k]);
        end
        pdu[6] = crc[7:0];
        pdu[7] = crc[15:8];
        if (corrupt) begin
            pos  = $urandom_range(FRAME_LEN - 1);
            bitn = $urandom_range(7);
            pdu[pos][bitn] = ~pdu[pos][bitn];
        end
        for (int k = 0; k < FRAME_LEN; k++) begin
            put_byte(pdu[k]);
        end
    endtask

    // start and quantity: mostly near the point map, sometimes anywhere
    function automatic logic [15:0] pick_field();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            return 16'($urandom_range(10));
        end
        if (r < 85) begin
            return 16'($urandom);
        end
        return 16'hFFFF;
    endfunction

    function automatic logic [7:0] pick_read_fn();
        return $urandom_range(1) ? FN_READ_COILS : FN_READ_INPUTS;
    endfunction

    task automatic issue_sequence();
        int         r;
        logic [7:0] fn;
        r = $urandom_range(99);
        if (r < 65) begin
            put_request(8'($urandom), pick_read_fn(), pick_field(), pick_field(), 1'b0);
            repeat (cur_silence) put_tick();
            // a stray tick with nothing held is ignored
            if ($urandom_range(3) == 0) begin
                put_tick();
            end
        end else if (r < 74) begin
            put_request(8'($urandom), pick_read_fn(), pick_field(), pick_field(), 1'b1);
            repeat (cur_silence) put_tick();
        end else if (r < 82) begin
            // function code other than the two served
            do begin
                fn = 8'($urandom);
            end while (fn == FN_READ_COILS || fn == FN_READ_INPUTS);
            put_request(8'($urandom), fn, pick_field(), pick_field(), 1'b0);
            repeat (cur_silence) put_tick();
        end else if (r < 89) begin
            // bytes past the eighth are counted, frame closes silently
            put_request(8'($urandom), pick_read_fn(), pick_field(), pick_field(), 1'b0);
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
            repeat (cur_silence) put_tick();
        end else if (r < 94) begin
            // short frame: ticks are ignored and the bytes stay counted
            repeat ($urandom_range(1, 7)) put_byte(8'($urandom));
            repeat ($urandom_range(1, 3)) put_tick();
        end else begin
            // silence broken by a late byte
            put_request(8'($urandom), pick_read_fn(), pick_field(), pick_field(), 1'b0);
            repeat ($urandom_range(cur_silence - 1)) put_tick();
            put_byte(8'($urandom));
            repeat (cur_silence) put_tick();
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            issue_sequence();
        end
    endtask

    // lower valid, let every reply leave and the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (backlog != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_silence(input logic [7:0] v);
        logic took;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do begin
            @(negedge i_clk);
            took = cfg_ready;
            @(posedge i_clk);
        end while (!took);
        cfg_valid   <= 1'b0;
        cur_silence  = v;
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset silence count, no idling: all eight coils from point 1
        put_request(8'h00, FN_READ_COILS, 16'd1, 16'd8, 1'b0);
        repeat (cur_silence - 1) put_tick();
        put_item(CMD_TICK, 8'h00, 8'hA5, 8'h00);
        // inputs from point 0 with the largest quantity
        put_request(8'hFF, FN_READ_INPUTS, 16'h0000, 16'hFFFF, 1'b0);
        repeat (cur_silence - 1) put_tick();
        put_item(CMD_TICK, 8'hFF, 8'hFF, 8'h5A);
        drain();

        // shortest silence, no idling
        set_silence(8'd1);
        run_random(30);
        drain();

        // sender mostly idle
        set_silence(8'($urandom_range(2, 8)));
        idle_pct = 80;
        run_random(30);
        drain();

        // sink mostly stalled
        set_silence(8'd3);
        idle_pct  = 0;
        stall_pct = 80;
        run_random(30);
        drain();

        // longer silence, light idling on both sides
        set_silence(8'd10);
        idle_pct  = 8;
        stall_pct = 8;
        repeat (2) begin
            put_request(8'($urandom), pick_read_fn(), pick_field(), pick_field(), 1'b0);
            repeat (cur_silence) put_tick();
        end
        drain();

        set_silence(8'($urandom_range(1, 8)));
        run_random(8);
        drain();

        if (errors == 0 && backlog == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/mrb_pkg.sv
rtl/mrb_ctrl.sv
rtl/mrb_dpath.sv
rtl/modbus_rtu_read_bits_slave.sv
verif/mrb_reply_checker.sv
verif/tb_modbus_rtu_read_bits_slave.sv
